>>> rtl/lgre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgre_pkg: shared types and constants of the Life generation row engine
// Widths, register indexes, limits and the result record used by all files.
// ----------------------------------------------------------------------------
package lgre_pkg;

    // Grid limits
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 1024;

    // Field widths
    localparam int ROW_W     = 64;   // cells carried by one row
    localparam int COL_W     = 7;    // column_count register
    localparam int ROW_CNT_W = 11;   // row_count register
    localparam int IDX_W     = 10;   // row_index field
    localparam int OUT_TDATA_W = 80; // next_row + row_index, padded to bytes

    // Largest frame that the row index can number
    localparam int ROW_LIMIT = (MAX_ROWS < (1 << IDX_W)) ? MAX_ROWS : (1 << IDX_W);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Life rule B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_W-1:0] next_row;
        logic [IDX_W-1:0] row_index;
        logic             frame_last;
    } t_result;

    // Results that one accepted row pushes into the queue
    typedef struct packed {
        logic a_valid;   // finished row above the arriving one
        logic b_valid;   // final row of the frame
    } t_push;

endpackage
`default_nettype wire

>>> rtl/lgre_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgre_cell: one lane of the row engine
// Counts the eight neighbors of one cell and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lgre_cell (
    input  wire logic [2:0] i_up,    // left, center, right of the row above
    input  wire logic [2:0] i_mid,   // left, center, right of this row
    input  wire logic [2:0] i_low,   // left, center, right of the row below
    output logic            o_alive
);

    logic [3:0] w_count;

    assign w_count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                   + 4'(i_mid[0]) + 4'(i_mid[2])
                   + 4'(i_low[0]) + 4'(i_low[1]) + 4'(i_low[2]);

    assign o_alive = (w_count == lgre_pkg::BIRTH_COUNT)
                   | (i_mid[1] & (w_count == lgre_pkg::SURVIVE_COUNT));

endmodule
`default_nettype wire

>>> rtl/lgre_row.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgre_row: one row of cell lanes
// Runs a lane per column side by side and merges the lane outputs into the
// next-generation row, clearing the columns outside the grid.
// ----------------------------------------------------------------------------
module lgre_row (
    input  wire logic [lgre_pkg::ROW_W-1:0] i_upper,
    input  wire logic [lgre_pkg::ROW_W-1:0] i_middle,
    input  wire logic [lgre_pkg::ROW_W-1:0] i_lower,
    input  wire logic [lgre_pkg::ROW_W-1:0] i_mask,
    output logic      [lgre_pkg::ROW_W-1:0] o_next
);

    // Dead cells pad both edges of the grid.
    logic [lgre_pkg::ROW_W+1:0] w_up_pad;
    logic [lgre_pkg::ROW_W+1:0] w_mid_pad;
    logic [lgre_pkg::ROW_W+1:0] w_low_pad;
    logic [lgre_pkg::ROW_W-1:0] w_lane;

    assign w_up_pad  = {1'b0, i_upper, 1'b0};
    assign w_mid_pad = {1'b0, i_middle, 1'b0};
    assign w_low_pad = {1'b0, i_lower, 1'b0};

    for (genvar g = 0; g < lgre_pkg::ROW_W; g++) begin : g_lane
        lgre_cell u_cell (
            .i_up   (w_up_pad[g+2:g]),
            .i_mid  (w_mid_pad[g+2:g]),
            .i_low  (w_low_pad[g+2:g]),
            .o_alive(w_lane[g])
        );
    end

    assign o_next = w_lane & i_mask;

endmodule
`default_nettype wire

>>> rtl/lgre_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgre_res_fifo: result queue of the row engine
// Takes up to two results a cycle and hands one a cycle to the output while it is ready.
// ----------------------------------------------------------------------------
module lgre_res_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lgre_pkg::t_push   i_push,
    input  wire lgre_pkg::t_result i_res_a,
    input  wire lgre_pkg::t_result i_res_b,
    output logic                   o_space,   // room for two more results
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lgre_pkg::t_result      o_res
);

    lgre_pkg::t_result              r_mem [lgre_pkg::FIFO_DEPTH];
    logic [lgre_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [lgre_pkg::PTR_W-1:0]     r_rd_ptr;
    logic [lgre_pkg::CNT_W-1:0]     r_count;
    logic [lgre_pkg::PTR_W-1:0]     n_wr_ptr;
    logic [lgre_pkg::PTR_W-1:0]     n_rd_ptr;
    logic [lgre_pkg::CNT_W-1:0]     n_count;
    logic [lgre_pkg::PTR_W-1:0]     w_wr_ptr_b;
    logic                           w_pop;

    assign o_valid    = (r_count != '0);
    assign o_res      = r_mem[r_rd_ptr];
    assign o_space    = (r_count <= lgre_pkg::CNT_W'(lgre_pkg::FIFO_DEPTH - 2));
    assign w_pop      = o_valid & i_ready;
    assign w_wr_ptr_b = r_wr_ptr + lgre_pkg::PTR_W'(i_push.a_valid);

    always_comb begin
        n_wr_ptr = r_wr_ptr + lgre_pkg::PTR_W'(i_push.a_valid)
                            + lgre_pkg::PTR_W'(i_push.b_valid);
        n_rd_ptr = r_rd_ptr + lgre_pkg::PTR_W'(w_pop);
        n_count  = r_count + lgre_pkg::CNT_W'(i_push.a_valid)
                           + lgre_pkg::CNT_W'(i_push.b_valid)
                           - lgre_pkg::CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_res_a;
        end
        if (i_push.b_valid) begin
            r_mem[w_wr_ptr_b] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The queue never holds more than it has entries for.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lgre_pkg::CNT_W'(lgre_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // Without a push or a pop the fill level holds.
    a_count_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.a_valid && !i_push.b_valid && !w_pop) |=> $stable(r_count))
        else $error("result queue level changed without traffic");

    // The two pointers are apart by exactly the fill level.
    a_ptr_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lgre_pkg::PTR_W'(r_wr_ptr - r_rd_ptr) == lgre_pkg::PTR_W'(r_count))
        else $error("result queue pointers disagree with level");

endmodule
`default_nettype wire

>>> rtl/life_generation_row_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_row_engine_top: one Life generation, streamed row by row
// Applies rule B3/S23 to a bounded grid that arrives one row per request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Marker
//  s_axis    in         tdata[63:0] row_cells                    -
//  m_axis    out        tdata[63:0] next_row, [73:64] row_index  tlast = frame_last
//  i_cfg_*   in         index 0 column_count, 1 row_count        write enable
//
// One row request is taken every clock cycle while the queue has room. Each row runs through two
// banks of 64 cell lanes in the same cycle, and the results go into a
// four-entry queue whose head entry drives the output ports directly, so a
// result that finds the queue empty is offered in the cycle after its row is taken.
// The first row of a frame yields nothing, each later row yields the row
// above it, and the last row also yields the final row, an extra result
// that the queue takes up.
// The input stalls only while the queue has room for fewer than two
// results, that is, when the output side stalls.
// Reset is synchronous: column_count returns to 64, row_count to 1024,
// the frame restarts and the queue empties.
// ----------------------------------------------------------------------------
module life_generation_row_engine_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [lgre_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lgre_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Input rows
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lgre_pkg::ROW_W-1:0]          s_axis_tdata,  // [63:0] row_cells

    // Next-generation rows
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lgre_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // [63:0] next_row,
                                                                    // [73:64] row_index,
                                                                    // [79:74] zero
    output logic                                     m_axis_tlast   // frame_last
);

    // Configuration registers
    logic [lgre_pkg::COL_W-1:0]     r_column_count;
    logic [lgre_pkg::ROW_CNT_W-1:0] r_row_count;

    // Frame state: the two rows above the arriving one and the rows taken
    logic [lgre_pkg::ROW_W-1:0]     r_upper_row;
    logic [lgre_pkg::ROW_W-1:0]     r_middle_row;
    logic [lgre_pkg::IDX_W-1:0]     r_rows_received;

    logic [lgre_pkg::COL_W-1:0]     w_cols;
    logic [lgre_pkg::ROW_CNT_W-1:0] w_total;
    logic [lgre_pkg::ROW_W-1:0]     w_mask;
    logic [lgre_pkg::ROW_W-1:0]     w_cur;
    logic [lgre_pkg::ROW_W-1:0]     w_next_a;
    logic [lgre_pkg::ROW_W-1:0]     w_next_b;
    logic                           w_accept;
    logic                           w_last;
    lgre_pkg::t_push                w_push;
    lgre_pkg::t_result              w_res_a;
    lgre_pkg::t_result              w_res_b;
    lgre_pkg::t_result              w_out;

    // ------------------------------------------------------------------
    // Configuration. The data is cut to each register's own width.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= lgre_pkg::COL_W'(64);
            r_row_count    <= lgre_pkg::ROW_CNT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lgre_pkg::REG_COLUMN_COUNT: r_column_count <= i_cfg_data[lgre_pkg::COL_W-1:0];
                lgre_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
            endcase
        end
    end

    // Column count of zero acts as one; too large a count is clipped.
    always_comb begin
        priority if (r_column_count == '0) begin
            w_cols = lgre_pkg::COL_W'(1);
        end else if (r_column_count > lgre_pkg::COL_W'(lgre_pkg::MAX_COLUMNS)) begin
            w_cols = lgre_pkg::COL_W'(lgre_pkg::MAX_COLUMNS);
        end else begin
            w_cols = r_column_count;
        end
    end

    // Row count of zero acts as one, so every row forms a frame of its own; too large a count is clipped.
    always_comb begin
        priority if (r_row_count == '0) begin
            w_total = lgre_pkg::ROW_CNT_W'(1);
        end else if (r_row_count > lgre_pkg::ROW_CNT_W'(lgre_pkg::ROW_LIMIT)) begin
            w_total = lgre_pkg::ROW_CNT_W'(lgre_pkg::ROW_LIMIT);
        end else begin
            w_total = r_row_count;
        end
    end

    for (genvar g = 0; g < lgre_pkg::ROW_W; g++) begin : g_mask
        assign w_mask[g] = (lgre_pkg::COL_W'(g) < w_cols);
    end

    assign w_cur    = s_axis_tdata & w_mask;
    assign w_accept = s_axis_tvalid & s_axis_tready;

    // The arriving row closes the frame once the rows taken reach the count.
    // This also covers a count lowered in the middle of a frame.
    assign w_last = ((lgre_pkg::ROW_CNT_W'(r_rows_received) + lgre_pkg::ROW_CNT_W'(1))
                     >= w_total);

    // ------------------------------------------------------------------
    // Two lane banks: the row above the arriving one, and the arriving row
    // itself with dead cells below it. At the start of a frame the middle
    // row is still clear, so the second bank then sees the lone first row.
    // ------------------------------------------------------------------
    lgre_row u_row_a (
        .i_upper (r_upper_row),
        .i_middle(r_middle_row),
        .i_lower (w_cur),
        .i_mask  (w_mask),
        .o_next  (w_next_a)
    );

    lgre_row u_row_b (
        .i_upper (r_middle_row),
        .i_middle(w_cur),
        .i_lower ('0),
        .i_mask  (w_mask),
        .o_next  (w_next_b)
    );

    // Merge stage: decide which results this row produces.
    always_comb begin
        w_push.a_valid     = w_accept & (r_rows_received != '0);
        w_push.b_valid     = w_accept & w_last;
        w_res_a.next_row   = w_next_a;
        w_res_a.row_index  = r_rows_received - lgre_pkg::IDX_W'(1);
        w_res_a.frame_last = 1'b0;
        w_res_b.next_row   = w_next_b;
        w_res_b.row_index  = r_rows_received;
        w_res_b.frame_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_row     <= '0;
            r_middle_row    <= '0;
            r_rows_received <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_upper_row     <= '0;
                r_middle_row    <= '0;
                r_rows_received <= '0;
            end else begin
                r_upper_row     <= r_middle_row;
                r_middle_row    <= w_cur;
                r_rows_received <= r_rows_received + lgre_pkg::IDX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue and output
    // ------------------------------------------------------------------
    lgre_res_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_res_a(w_res_a),
        .i_res_b(w_res_b),
        .o_space(s_axis_tready),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_res  (w_out)
    );

    assign m_axis_tdata = {{(lgre_pkg::OUT_TDATA_W - lgre_pkg::ROW_W - lgre_pkg::IDX_W){1'b0}},
                           w_out.row_index, w_out.next_row};
    assign m_axis_tlast = w_out.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A fresh frame starts with both stored rows clear.
    a_frame_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows_received == '0) |-> (r_middle_row == '0 && r_upper_row == '0))
        else $error("stored rows not clear at frame start");

    // The last row of a frame returns the engine to the frame start.
    a_frame_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_rows_received == '0))
        else $error("frame did not restart after its last row");

    // The row counter never runs past the last row of the largest frame.
    a_row_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_received <= lgre_pkg::IDX_W'(lgre_pkg::ROW_LIMIT - 1))
        else $error("row counter out of range");

endmodule
`default_nettype wire
